/* rtl/mds_pkg.sv */
package mds_pkg;

	// Fixed widths of the request and result fields.
	localparam int VALUE_W  = 16;
	localparam int COUNT_W  = 5;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// Request operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_COUNT  = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Command broadcast to every cell of the row.
	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_PUSH = 3'd1,
		CELL_POP  = 3'd2,
		CELL_MARK = 3'd3,
		CELL_TAKE = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     remove;
	} cell_ctl_t;

endpackage

/* rtl/mds_cell.sv */
module mds_cell #(
	parameter int ITEM_BITS = 16,
	parameter int LVL_W     = 5,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  mds_pkg::cell_ctl_t   ctl,
	input  logic [ITEM_BITS-1:0] target,
	input  logic [LVL_W-1:0]     fill,
	input  logic [ITEM_BITS-1:0] prev_data,
	input  logic [ITEM_BITS-1:0] next_data,
	input  logic                 next_hit,
	input  logic                 seen_in,
	output logic                 seen_out,
	output logic [ITEM_BITS-1:0] data,
	output logic                 hit
);

	logic [ITEM_BITS-1:0] data_q;
	logic                 hit_q;
	logic                 in_range;
	logic                 first_hit;

	// The cell only holds a live entry when it lies below the fill level.
	assign in_range  = LVL_W'(IDX) < fill;
	assign first_hit = hit_q && !seen_in;
	assign seen_out  = seen_in || hit_q;
	assign data      = data_q;
	assign hit       = hit_q;

	// Entry storage: shifts with its neighbors, and marks or drops matches.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			mds_pkg::CELL_PUSH: begin
				data_q <= prev_data;
			end
			mds_pkg::CELL_POP: begin
				data_q <= next_data;
			end
			mds_pkg::CELL_MARK: begin
				hit_q <= in_range && (data_q == target);
			end
			mds_pkg::CELL_TAKE: begin
				// Delete closes the gap from the first mark; count clears it.
				if (ctl.remove && (seen_in || hit_q)) begin
					data_q <= next_data;
					hit_q  <= next_hit;
				end else if (first_hit) begin
					hit_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/match_delete_stack_top.sv */
// Channel   Direction  Handshake               Payload
// request   in         in_valid / in_ready     op, value
// result    out        out_valid / out_ready   front_item, match_count, entry_count,
//                                              is_empty, status
//
// One request is worked at a time. Push and pop pass from the execute state to
// the done state; count and delete pass through a scan state in between, in
// which the cell row retires one marked match per cycle until none is left.
// Reset clears the fill level, the sequencer and the result valid flag; the cell
// contents are not reset. A result held by a stalled consumer lets the next
// request be accepted, but that request's result waits until the slot frees.
module match_delete_stack_top #(
	parameter int DEPTH     = 16,
	parameter int ITEM_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mds_pkg::OP_W-1:0]      op,
	input  logic [mds_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mds_pkg::VALUE_W-1:0]   front_item,
	output logic [mds_pkg::COUNT_W-1:0]   match_count,
	output logic [mds_pkg::COUNT_W-1:0]   entry_count,
	output logic                          is_empty,
	output logic [mds_pkg::STATUS_W-1:0]  status
);

	localparam int LVL_W = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t               state_q;
	mds_pkg::op_t         op_q;
	logic [ITEM_BITS-1:0] val_q;
	logic [LVL_W-1:0]     fill_q;
	logic [LVL_W-1:0]     cnt_q;
	mds_pkg::status_t     status_q;

	logic                          out_valid_q;
	logic [mds_pkg::VALUE_W-1:0]   front_q;
	logic [mds_pkg::COUNT_W-1:0]   match_q;
	logic [mds_pkg::COUNT_W-1:0]   entries_q;
	logic                          empty_q;
	logic [mds_pkg::STATUS_W-1:0]  status_out_q;

	mds_pkg::cell_ctl_t   ctl;
	logic [ITEM_BITS-1:0] cell_data [DEPTH];
	logic                 cell_hit  [DEPTH];
	logic                 seen      [DEPTH+1];
	logic                 full;
	logic                 empty;
	logic                 out_load;

	assign full     = fill_q == LVL_W'(DEPTH);
	assign empty    = fill_q == '0;
	assign in_ready = state_q == S_IDLE;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign seen[0]  = 1'b0;

	// Row of entry cells, front entry in cell 0.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ITEM_BITS-1:0] prev_d;
		logic [ITEM_BITS-1:0] next_d;
		logic                 next_h;

		if (i == 0) begin : g_first
			assign prev_d = val_q;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = cell_data[i];
			assign next_h = 1'b0;
		end else begin : g_inner
			assign next_d = cell_data[i+1];
			assign next_h = cell_hit[i+1];
		end

		mds_cell #(
			.ITEM_BITS(ITEM_BITS),
			.LVL_W    (LVL_W),
			.IDX      (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.target   (val_q),
			.fill     (fill_q),
			.prev_data(prev_d),
			.next_data(next_d),
			.next_hit (next_h),
			.seen_in  (seen[i]),
			.seen_out (seen[i+1]),
			.data     (cell_data[i]),
			.hit      (cell_hit[i])
		);
	end

	// Command to the cell row for the current step.
	always_comb begin
		ctl.op     = mds_pkg::CELL_HOLD;
		ctl.remove = op_q == mds_pkg::OP_DELETE;
		unique case (state_q)
			S_EXEC: begin
				case (op_q)
					mds_pkg::OP_PUSH: if (!full) ctl.op = mds_pkg::CELL_PUSH;
					mds_pkg::OP_POP:  if (!empty) ctl.op = mds_pkg::CELL_POP;
					default:          ctl.op = mds_pkg::CELL_MARK;
				endcase
			end
			S_SCAN: begin
				ctl.op = mds_pkg::CELL_TAKE;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, fill level and match counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			cnt_q    <= '0;
			op_q     <= mds_pkg::OP_PUSH;
			status_q <= mds_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= mds_pkg::op_t'(op);
						cnt_q    <= '0;
						status_q <= mds_pkg::ST_OK;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						mds_pkg::OP_PUSH: begin
							if (full) status_q <= mds_pkg::ST_FULL;
							else fill_q <= fill_q + LVL_W'(1);
							state_q <= S_DONE;
						end
						mds_pkg::OP_POP: begin
							if (empty) status_q <= mds_pkg::ST_UNDERFLOW;
							else fill_q <= fill_q - LVL_W'(1);
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					// One marked match retires per cycle until none is left.
					if (seen[DEPTH]) begin
						cnt_q <= cnt_q + LVL_W'(1);
						if (op_q == mds_pkg::OP_DELETE) fill_q <= fill_q - LVL_W'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The request value needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) val_q <= ITEM_BITS'(value);
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			front_q      <= empty ? '0 : mds_pkg::VALUE_W'(cell_data[0]);
			match_q      <= mds_pkg::COUNT_W'(cnt_q);
			entries_q    <= mds_pkg::COUNT_W'(fill_q);
			empty_q      <= empty;
			status_out_q <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign front_item  = front_q;
	assign match_count = match_q;
	assign entry_count = entries_q;
	assign is_empty    = empty_q;
	assign status      = status_out_q;

	// The fill level never passes the row length.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LVL_W'(DEPTH))
		else $error("fill level beyond depth");

	// A scan never retires more matches than there are cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cnt_q <= LVL_W'(DEPTH))
		else $error("match count beyond depth");

	// An underflow result always reports an empty list.
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && status_q == mds_pkg::ST_UNDERFLOW |=> is_empty && entry_count == '0)
		else $error("underflow reported on a non-empty list");

	// A dropped push reports a full list.
	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && status_q == mds_pkg::ST_FULL |-> fill_q == LVL_W'(DEPTH))
		else $error("full status without a full list");

endmodule
